FILE: design/msb_pkg.sv
// merge sort buffer package: sizes, memory request and result structs
// depends on nothing; used by msb_if, msb_seq and merge_sort_buffer_top
package msb_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int STORE_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// one write and one read request to a storage bank
	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		addr_t raddr;
	} ram_req_t;

	// one result item handed to the output register
	typedef struct packed {
		logic  valid;
		data_t value;
		logic  final_res;
		logic  overflow;
	} result_t;

endpackage

FILE: design/msb_if.sv
// valid/ready channel interfaces of the merge sort buffer
// depends on msb_pkg for the data width
interface msb_in_if;
	logic                valid;
	logic                ready;
	logic signed [msb_pkg::DATA_W-1:0] value;
	logic                last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface msb_out_if;
	logic                valid;
	logic                ready;
	logic signed [msb_pkg::DATA_W-1:0] sorted_value;
	logic                final_res;
	logic                overflow;

	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface

FILE: design/msb_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module msb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/msb_seq.sv
// sequencer of the merge sort buffer: load, bottom-up merge passes, readout
// depends on msb_pkg; drives the two storage banks through ram_req_t
module msb_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  msb_pkg::data_t    in_value,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              out_free,
	input  msb_pkg::data_t    rdata_a,
	input  msb_pkg::data_t    rdata_b,
	output msb_pkg::ram_req_t req_a,
	output msb_pkg::ram_req_t req_b,
	output msb_pkg::result_t  emit
);

	localparam logic [2:0] S_LOAD   = 3'd0;
	localparam logic [2:0] S_RUN0   = 3'd1;
	localparam logic [2:0] S_RUN1   = 3'd2;
	localparam logic [2:0] S_RUN2   = 3'd3;
	localparam logic [2:0] S_MERGE  = 3'd4;
	localparam logic [2:0] S_OREAD  = 3'd5;
	localparam logic [2:0] S_OLATCH = 3'd6;

	localparam int POS_W = msb_pkg::CNT_W + 1;

	logic [2:0]          state_q;
	msb_pkg::cnt_t       count_q;
	logic                dropped_q;
	logic                bank_q;
	msb_pkg::cnt_t       width_q;
	msb_pkg::cnt_t       lo_q;
	msb_pkg::cnt_t       mid_q;
	msb_pkg::cnt_t       hi_q;
	msb_pkg::cnt_t       i_q;
	msb_pkg::cnt_t       j_q;
	msb_pkg::cnt_t       k_q;
	msb_pkg::data_t      a_q;
	msb_pkg::data_t      b_q;
	logic                fwd_a_q;
	logic                fwd_b_q;

	msb_pkg::data_t      src_rdata;
	msb_pkg::data_t      a_cur;
	msb_pkg::data_t      b_cur;
	msb_pkg::data_t      pick;
	logic [POS_W-1:0]    mid_sum;
	logic [POS_W-1:0]    hi_sum;
	msb_pkg::cnt_t       mid_n;
	msb_pkg::cnt_t       hi_n;
	msb_pkg::cnt_t       k_inc;
	msb_pkg::cnt_t       i_inc;
	msb_pkg::cnt_t       j_inc;
	logic                has_a;
	logic                has_b;
	logic                take_a;
	logic                accept;
	logic                room;
	logic                run_done;
	logic                last_out;
	msb_pkg::ram_req_t   src_req;
	msb_pkg::ram_req_t   dst_req;

	assign src_rdata = bank_q ? rdata_b : rdata_a;
	assign a_cur     = fwd_a_q ? src_rdata : a_q;
	assign b_cur     = fwd_b_q ? src_rdata : b_q;

	assign mid_sum = {1'b0, lo_q} + {1'b0, width_q};
	assign hi_sum  = {1'b0, lo_q} + {width_q, 1'b0};
	assign mid_n   = (mid_sum > {1'b0, count_q}) ? count_q : mid_sum[msb_pkg::CNT_W-1:0];
	assign hi_n    = (hi_sum > {1'b0, count_q}) ? count_q : hi_sum[msb_pkg::CNT_W-1:0];

	assign k_inc = k_q + msb_pkg::CNT_W'(1);
	assign i_inc = i_q + msb_pkg::CNT_W'(1);
	assign j_inc = j_q + msb_pkg::CNT_W'(1);

	// equal heads take the right run
	assign has_a  = i_q < mid_q;
	assign has_b  = j_q < hi_q;
	assign take_a = has_a && (!has_b || ($signed(a_cur) < $signed(b_cur)));
	assign pick   = take_a ? a_cur : b_cur;

	assign run_done = (k_inc == hi_q);
	assign last_out = (k_inc == count_q);

	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;
	assign room     = count_q < msb_pkg::CNT_W'(msb_pkg::MAX_ITEMS);

	// bank requests: reads always go to the source bank, merge writes to the other
	always_comb begin
		src_req = '0;
		dst_req = '0;
		case (state_q)
			S_RUN0: begin
				src_req.raddr = lo_q[msb_pkg::ADDR_W-1:0];
			end
			S_RUN1: begin
				src_req.raddr = mid_q[msb_pkg::ADDR_W-1:0];
			end
			S_MERGE: begin
				src_req.raddr = take_a ? i_inc[msb_pkg::ADDR_W-1:0]
					: j_inc[msb_pkg::ADDR_W-1:0];
				dst_req.we    = 1'b1;
				dst_req.waddr = k_q[msb_pkg::ADDR_W-1:0];
				dst_req.wdata = pick;
			end
			S_OREAD: begin
				src_req.raddr = k_q[msb_pkg::ADDR_W-1:0];
			end
			default: begin
				src_req = '0;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_LOAD) begin
			req_a       = '0;
			req_a.we    = accept && room;
			req_a.waddr = count_q[msb_pkg::ADDR_W-1:0];
			req_a.wdata = in_value;
			req_b       = '0;
		end else if (bank_q) begin
			req_a = dst_req;
			req_b = src_req;
		end else begin
			req_a = src_req;
			req_b = dst_req;
		end
	end

	always_comb begin
		emit.valid     = (state_q == S_OLATCH);
		emit.value     = src_rdata;
		emit.final_res = last_out;
		emit.overflow  = dropped_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			bank_q    <= 1'b0;
			width_q   <= '0;
			lo_q      <= '0;
			k_q       <= '0;
			fwd_a_q   <= 1'b0;
			fwd_b_q   <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + msb_pkg::CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (in_last) begin
							width_q <= msb_pkg::CNT_W'(1);
							lo_q    <= '0;
							bank_q  <= 1'b0;
							state_q <= S_RUN0;
						end
					end
				end
				S_RUN0: begin
					if (width_q >= count_q) begin
						k_q     <= '0;
						state_q <= S_OREAD;
					end else begin
						k_q     <= lo_q;
						state_q <= S_RUN1;
					end
				end
				S_RUN1: begin
					state_q <= S_RUN2;
				end
				S_RUN2: begin
					fwd_a_q <= 1'b0;
					fwd_b_q <= 1'b0;
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					k_q     <= k_inc;
					fwd_a_q <= take_a;
					fwd_b_q <= !take_a;
					if (run_done) begin
						fwd_a_q <= 1'b0;
						fwd_b_q <= 1'b0;
						state_q <= S_RUN0;
						if (hi_q >= count_q) begin
							width_q <= {width_q[msb_pkg::CNT_W-2:0], 1'b0};
							lo_q    <= '0;
							bank_q  <= !bank_q;
						end else begin
							lo_q <= hi_q;
						end
					end
				end
				S_OREAD: begin
					if (out_free) begin
						state_q <= S_OLATCH;
					end
				end
				S_OLATCH: begin
					k_q <= k_inc;
					if (last_out) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= S_LOAD;
					end else begin
						state_q <= S_OREAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// run bounds, pointers and head values
	always_ff @(posedge clk) begin
		case (state_q)
			S_RUN0: begin
				mid_q <= mid_n;
				hi_q  <= hi_n;
				i_q   <= lo_q;
				j_q   <= mid_n;
			end
			S_RUN1: begin
				a_q <= src_rdata;
			end
			S_RUN2: begin
				b_q <= src_rdata;
			end
			S_MERGE: begin
				a_q <= a_cur;
				b_q <= b_cur;
				if (take_a) begin
					i_q <= i_inc;
				end else begin
					j_q <= j_inc;
				end
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

endmodule

FILE: design/merge_sort_buffer_top.sv
// loading accepts one item per cycle; after the last item the set of n is sorted in
// ceil(log2 n) merge passes, then read out one result at a time while the output register
// is free; throughput set by the single read port of the source bank
// reset: asynchronous, active low; buffer empty, overflow flag clear, memories undefined
// depends on msb_pkg, msb_if, msb_ram and msb_seq
module merge_sort_buffer_top (
	input  logic       clk,
	input  logic       arst_n,
	msb_in_if.sink     in_item,
	msb_out_if.source  out_item
);

	// two banks: bank a takes the loaded items, merge passes ping-pong between them
	msb_pkg::ram_req_t req_a;
	msb_pkg::ram_req_t req_b;
	msb_pkg::data_t    rdata_a;
	msb_pkg::data_t    rdata_b;
	msb_pkg::result_t  emit;

	// output register parts the sequencer from the consumer
	logic              out_valid_q;
	msb_pkg::data_t    out_value_q;
	logic              out_final_q;
	logic              out_ovf_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_item.ready;

	msb_ram #(
		.WIDTH(msb_pkg::DATA_W),
		.DEPTH(msb_pkg::STORE_DEPTH)
	) u_bank_a (
		.clk  (clk),
		.we   (req_a.we),
		.waddr(req_a.waddr),
		.wdata(req_a.wdata),
		.raddr(req_a.raddr),
		.rdata(rdata_a)
	);

	msb_ram #(
		.WIDTH(msb_pkg::DATA_W),
		.DEPTH(msb_pkg::STORE_DEPTH)
	) u_bank_b (
		.clk  (clk),
		.we   (req_b.we),
		.waddr(req_b.waddr),
		.wdata(req_b.wdata),
		.raddr(req_b.raddr),
		.rdata(rdata_b)
	);

	// sequencer: load, merge passes, ordered readout
	msb_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_item.valid),
		.in_value(in_item.value),
		.in_last (in_item.last),
		.in_ready(in_item.ready),
		.out_free(out_free),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.req_a   (req_a),
		.req_b   (req_b),
		.emit    (emit)
	);

	// the sequencer only emits when the register is free at that edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_value_q <= emit.value;
			out_final_q <= emit.final_res;
			out_ovf_q   <= emit.overflow;
		end
	end

	assign out_item.valid        = out_valid_q;
	assign out_item.sorted_value = out_value_q;
	assign out_item.final_res    = out_final_q;
	assign out_item.overflow     = out_ovf_q;

endmodule
